// ----- hdl/sorted_id_binary_search_core_macros.svh -----
// assertion macros for the sorted identifier search core
// used by the top level only, needs no other file
`ifndef SORTED_ID_BINARY_SEARCH_CORE_MACROS_SVH
`define SORTED_ID_BINARY_SEARCH_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SIBS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define SIBS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/sibs_pkg.sv -----
// shared types and constants of the sorted identifier search core
// no dependencies; used by the controller, datapath and top level
`timescale 1ns / 1ps
`default_nettype none

package sibs_pkg;

   localparam int DEPTH   = 256;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = ADDR_W + 1;
   localparam int ID_W    = 16;

   // operation codes carried in req_tuser
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_COMPARE
   } state_type;

   typedef struct packed {
      logic write_en;
      logic load_search;
      logic read_probe;
      logic step;
      logic load_rsp;
      logic rsp_hit;
   } cmd_type;

   typedef struct packed {
      logic active;
      logic equal;
      logic rsp_free;
   } status_type;

endpackage

`default_nettype wire

// ----- hdl/sorted_id_binary_search_core.sv -----
// Sorted identifier table with binary-search lookup.
// Request channel (req_*): req_tuser selects the operation, 0 stores key_id
// into slot, 1 searches for key_id. Writes give no response.
// Response channel (rsp_*): one item per search, tuser = found flag, tdata =
// position (0 on a miss). csr_we/csr_wdata load entries_in_use (values above
// 256 act as 256); write it only while the core is idle.
// A write is stored as it is accepted. A search runs each probe as a table
// read (CHECK) then a compare (COMPARE), at most nine probes for 256 entries.
// A hit responds from the compare that matches, a miss from the check that
// finds the range empty; the next request is taken the cycle after the
// response is loaded.
// The response sits in an output register: the core accepts new requests
// while it waits; a finished search only holds if that register is still full.
// Synchronous reset clears entries_in_use and the response valid; the table
// itself is not cleared and must be written before it is searched.
// Software must load the identifiers in ascending order.
// Depends on sibs_pkg, sibs_ctrl, sibs_datapath and the macros header.
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_id_binary_search_core_macros.svh"

module sorted_id_binary_search_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // [7:0] slot, [23:8] key_id
   input  wire  [0:0]  req_tuser,   // [0] operation
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] position
   output logic [0:0]  rsp_tuser,   // [0] found
   input  wire         csr_we,
   input  wire  [8:0]  csr_wdata    // entries_in_use
);

   sibs_pkg::cmd_type    cmd;
   sibs_pkg::status_type status;
   logic                 rsp_found;
   logic [7:0]           rsp_position;

   sibs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser[0]),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   sibs_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .req_slot     (req_tdata[7:0]),
      .req_key      (req_tdata[23:8]),
      .cmd          (cmd),
      .status       (status),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_found    (rsp_found),
      .rsp_position (rsp_position)
   );

   assign rsp_tdata    = rsp_position;
   assign rsp_tuser[0] = rsp_found;

   `SIBS_ASSERT_NOW(a_no_rsp_overwrite, clock, reset, cmd.load_rsp, status.rsp_free, "response overwritten while pending")
   `SIBS_ASSERT_NOW(a_probe_in_range, clock, reset, cmd.read_probe, status.active, "probe issued on empty range")
   `SIBS_ASSERT_NOW(a_idle_no_probe, clock, reset, req_tready, !cmd.read_probe && !cmd.step, "request taken during search")
   `SIBS_ASSERT_NEXT(a_miss_pos_zero, clock, reset, cmd.load_rsp && !cmd.rsp_hit, rsp_tvalid && rsp_tuser[0] == 1'b0 && rsp_tdata == 8'd0, "miss with nonzero position")

endmodule

`default_nettype wire

// ----- hdl/sibs_datapath.sv -----
// datapath: identifier table memory, search bounds, compare and result register
// depends on sibs_pkg
`timescale 1ns / 1ps
`default_nettype none

module sibs_datapath (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_we,
   input  wire [sibs_pkg::CNT_W-1:0]    csr_wdata,
   input  wire [sibs_pkg::ADDR_W-1:0]   req_slot,
   input  wire [sibs_pkg::ID_W-1:0]     req_key,
   input  sibs_pkg::cmd_type            cmd,
   output sibs_pkg::status_type         status,
   input  wire                          rsp_tready,
   output logic                         rsp_tvalid,
   output logic                         rsp_found,
   output logic [sibs_pkg::ADDR_W-1:0]  rsp_position
);

   logic [sibs_pkg::ID_W-1:0]   mem [sibs_pkg::DEPTH];
   logic [sibs_pkg::ID_W-1:0]   rd_data_ff;

   logic [sibs_pkg::CNT_W-1:0]  count_ff;
   logic [sibs_pkg::CNT_W-1:0]  count_sat;
   logic [sibs_pkg::ID_W-1:0]   key_ff;
   // low bound and one past the high bound
   logic [sibs_pkg::CNT_W-1:0]  low_ff, low_in;
   logic [sibs_pkg::CNT_W-1:0]  hi1_ff, hi1_in;
   logic [sibs_pkg::ADDR_W-1:0] mid_ff;
   logic [sibs_pkg::CNT_W-1:0]  span;
   logic [sibs_pkg::CNT_W-1:0]  mid_wide;
   logic [sibs_pkg::ADDR_W-1:0] mid;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        found_ff;
   logic [sibs_pkg::ADDR_W-1:0] pos_ff;

   always_ff @(posedge clock) begin
      if (cmd.write_en) begin
         mem[req_slot] <= req_key;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_probe) begin
         rd_data_ff <= mem[mid];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_we) begin
         count_ff <= csr_wdata;
      end
   end

   always_comb begin
      if (count_ff > sibs_pkg::CNT_W'(sibs_pkg::DEPTH)) begin
         count_sat = sibs_pkg::CNT_W'(sibs_pkg::DEPTH);
      end else begin
         count_sat = count_ff;
      end
   end

   // probe = low + (high - low) / 2 with high = hi1 - 1, valid while low < hi1
   assign span     = hi1_ff - low_ff - sibs_pkg::CNT_W'(1);
   assign mid_wide = low_ff + (span >> 1);
   assign mid      = mid_wide[sibs_pkg::ADDR_W-1:0];

   always_comb begin
      low_in = low_ff;
      hi1_in = hi1_ff;
      if (cmd.load_search) begin
         low_in = '0;
         hi1_in = count_sat;
      end else if (cmd.step) begin
         if (rd_data_ff < key_ff) begin
            low_in = {1'b0, mid_ff} + sibs_pkg::CNT_W'(1);
         end else begin
            hi1_in = {1'b0, mid_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      low_ff <= low_in;
      hi1_ff <= hi1_in;
      if (cmd.load_search) begin
         key_ff <= req_key;
      end
      if (cmd.read_probe) begin
         mid_ff <= mid;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         found_ff <= cmd.rsp_hit;
         pos_ff   <= cmd.rsp_hit ? mid_ff : '0;
      end
   end

   assign status.active   = (low_ff < hi1_ff);
   assign status.equal    = (rd_data_ff == key_ff);
   assign status.rsp_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_found    = found_ff;
   assign rsp_position = pos_ff;

endmodule

`default_nettype wire

// ----- hdl/sibs_ctrl.sv -----
// controller state machine: accepts requests and sequences the search probes
// depends on sibs_pkg
`timescale 1ns / 1ps
`default_nettype none

module sibs_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   input  wire                   req_op,
   input  sibs_pkg::status_type  status,
   output logic                  req_tready,
   output sibs_pkg::cmd_type     cmd
);

   sibs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sibs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sibs_pkg::ST_IDLE: begin
            if (req_tvalid && req_op == sibs_pkg::OP_SEARCH) begin
               state_in = sibs_pkg::ST_CHECK;
            end
         end
         sibs_pkg::ST_CHECK: begin
            if (status.active) begin
               state_in = sibs_pkg::ST_COMPARE;
            end else if (status.rsp_free) begin
               state_in = sibs_pkg::ST_IDLE;
            end
         end
         sibs_pkg::ST_COMPARE: begin
            if (!status.equal) begin
               state_in = sibs_pkg::ST_CHECK;
            end else if (status.rsp_free) begin
               state_in = sibs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sibs_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         sibs_pkg::ST_IDLE: begin
            req_tready      = 1'b1;
            cmd.write_en    = req_tvalid && req_op == sibs_pkg::OP_WRITE;
            cmd.load_search = req_tvalid && req_op == sibs_pkg::OP_SEARCH;
         end
         sibs_pkg::ST_CHECK: begin
            // empty range means a miss; hold until the result register frees
            cmd.read_probe = status.active;
            cmd.load_rsp   = !status.active && status.rsp_free;
         end
         sibs_pkg::ST_COMPARE: begin
            cmd.step     = !status.equal;
            cmd.load_rsp = status.equal && status.rsp_free;
            cmd.rsp_hit  = status.equal;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// self-checking testbench for sorted_id_binary_search_core: loads id tables,
// runs lookups under random stalls and checks each response against a predictor
// depends on sibs_pkg and the core sources
`timescale 1ns / 1ps

module tb_top;

   typedef struct packed {
      logic                        found;
      logic [sibs_pkg::ADDR_W-1:0] position;
   } lookup_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [23:0] req_tdata = '0;   // [7:0] slot, [23:8] key_id
   logic [0:0]  req_tuser = '0;   // [0] operation
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [7:0]  rsp_tdata;        // [7:0] position
   wire  [0:0]  rsp_tuser;        // [0] found
   logic        csr_we = 1'b0;
   logic [8:0]  csr_wdata = '0;

   // predictor state: table copy and entry count
   logic [sibs_pkg::ID_W-1:0]  id_copy [sibs_pkg::DEPTH];
   logic [sibs_pkg::CNT_W-1:0] count_copy = '0;
   lookup_type                 expected_lookups [$];

   int errors = 0;
   int lookups_checked = 0;
   int hits_seen = 0;
   int writes_sent = 0;
   int searches_sent = 0;
   int send_idle_pct = 24;
   int recv_idle_pct = 50;
   int hold_cycles = 0;
   int hold_seq = 0;

   sorted_id_binary_search_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("%0t: timeout with %0d lookups outstanding", $time, expected_lookups.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int active_span();
      return (count_copy > sibs_pkg::DEPTH) ? sibs_pkg::DEPTH : int'(count_copy);
   endfunction

   // binary search over the copied table, stops on the first equal probe
   function automatic lookup_type predict_lookup(logic [sibs_pkg::ID_W-1:0] key);
      int lo;
      int hi;
      int mid;
      lookup_type res;
      res = '0;
      lo = 0;
      hi = active_span() - 1;
      while (lo <= hi && !res.found) begin
         mid = lo + (hi - lo) / 2;
         if (id_copy[mid] == key) begin
            res.found = 1'b1;
            res.position = sibs_pkg::ADDR_W'(mid);
         end else if (id_copy[mid] < key) begin
            lo = mid + 1;
         end else begin
            hi = mid - 1;
         end
      end
      return res;
   endfunction

   task automatic send_request(logic op, logic [7:0] slot, logic [sibs_pkg::ID_W-1:0] key);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {key, slot};
      do @(posedge clock); while (!req_tready);
      if (op == sibs_pkg::OP_WRITE) begin
         id_copy[slot] = key;
         writes_sent++;
      end else begin
         expected_lookups.push_back(predict_lookup(key));
         searches_sent++;
      end
   endtask

   task automatic search_for(logic [sibs_pkg::ID_W-1:0] key);
      send_request(sibs_pkg::OP_SEARCH, 8'($urandom_range(255)), key);
   endtask

   // a write gives no response, so allow a full search time after the last one
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_lookups.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   task automatic write_count(int value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value[8:0];
      @(posedge clock);
      csr_we <= 1'b0;
      count_copy = value[sibs_pkg::CNT_W-1:0];
   endtask

   task automatic test_empty_table();
      write_count(0);
      search_for(16'h0000);
      search_for(16'hffff);
      search_for(16'($urandom_range(65535)));
   endtask

   task automatic test_directed_lookups();
      logic [sibs_pkg::ID_W-1:0] seed_ids [8];
      seed_ids = '{16'h0000, 16'h0001, 16'h00ff, 16'h1234,
                   16'h1234, 16'h1234, 16'h8000, 16'hffff};
      for (int i = 0; i < 8; i++) send_request(sibs_pkg::OP_WRITE, 8'(i), seed_ids[i]);
      send_request(sibs_pkg::OP_WRITE, 8'hff, 16'habcd);
      write_count(8);
      search_for(16'h0000);
      search_for(16'hffff);
      search_for(16'h1234);   // duplicates
      search_for(16'h8000);
      search_for(16'h0002);
      search_for(16'hfffe);
      search_for(16'h9000);
      // single entry, low and high start equal
      write_count(1);
      search_for(16'h0000);
      search_for(16'h0005);
      write_count(2);
      search_for(16'h0001);
      search_for(16'h0000);
   endtask

   task automatic test_unsorted_table();
      write_count(8);
      send_request(sibs_pkg::OP_WRITE, 8'd3, 16'hffff);
      search_for(16'h1234);
      search_for(16'hffff);
      search_for(16'h00ff);
   endtask

   task automatic load_full_table();
      int acc;
      acc = 0;
      for (int s = 0; s < sibs_pkg::DEPTH; s++) begin
         if ($urandom_range(3) != 0) acc += $urandom_range(500);
         if (acc > 65535) acc = 65535;
         send_request(sibs_pkg::OP_WRITE, 8'(s), acc[sibs_pkg::ID_W-1:0]);
      end
   endtask

   task automatic test_full_table();
      load_full_table();
      write_count(sibs_pkg::DEPTH);
      for (int i = 0; i < 6; i++) search_for(id_copy[$urandom_range(sibs_pkg::DEPTH - 1)]);
      search_for(16'h0000);
      search_for(16'hffff);
      // count beyond the table size saturates
      write_count(511);
      search_for(id_copy[0]);
      search_for(id_copy[sibs_pkg::DEPTH - 1]);
   endtask

   task automatic test_random_traffic(int items, int send_pct, int recv_pct, int count);
      int pick;
      int span;
      int s;
      logic [sibs_pkg::ID_W-1:0] lo_k;
      logic [sibs_pkg::ID_W-1:0] hi_k;
      write_count(count);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      span = active_span();
      for (int n = 0; n < items; n++) begin
         pick = $urandom_range(99);
         s = $urandom_range(span - 1);
         if (pick < 62) begin
            search_for(id_copy[s]);
         end else if (pick < 72) begin
            search_for(id_copy[s] + (($urandom_range(1) != 0) ? 16'd1 : 16'hffff));
         end else if (pick < 80) begin
            search_for(16'($urandom_range(65535)));
         end else if (pick < 95) begin
            // rewrite a slot keeping the order intact where it still is
            s = $urandom_range(sibs_pkg::DEPTH - 1);
            lo_k = (s == 0) ? 16'h0000 : id_copy[s - 1];
            hi_k = (s == sibs_pkg::DEPTH - 1) ? 16'hffff : id_copy[s + 1];
            if (lo_k <= hi_k)
               send_request(sibs_pkg::OP_WRITE, 8'(s), 16'($urandom_range(hi_k, lo_k)));
            else
               send_request(sibs_pkg::OP_WRITE, 8'(s), 16'($urandom_range(65535)));
         end else begin
            send_request(sibs_pkg::OP_WRITE, 8'($urandom_range(255)),
                         16'($urandom_range(65535)));
         end
      end
   endtask

   task automatic test_backpressure();
      write_count(sibs_pkg::DEPTH);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles = 300;
      hold_seq <= hold_seq + 1;
      for (int n = 0; n < 60; n++) search_for(id_copy[$urandom_range(sibs_pkg::DEPTH - 1)]);
   endtask

   // response checker and receiver stall control
   initial begin : rsp_monitor
      lookup_type exp_lookup;
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (expected_lookups.size() == 0) begin
               $display("%0t: unexpected response, expected none, got found %0b position %0d",
                        $time, rsp_tuser[0], rsp_tdata);
               errors++;
            end else begin
               exp_lookup = expected_lookups.pop_front();
               lookups_checked++;
               if (rsp_tuser[0] !== exp_lookup.found) begin
                  $display("%0t: found mismatch, expected %0b, got %0b",
                           $time, exp_lookup.found, rsp_tuser[0]);
                  errors++;
               end
               if (rsp_tdata !== exp_lookup.position) begin
                  $display("%0t: position mismatch, expected %0d, got %0d",
                           $time, exp_lookup.position, rsp_tdata);
                  errors++;
               end
               if (exp_lookup.found) hits_seen++;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = hold_cycles;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_directed_lookups();
      test_unsorted_table();
      test_full_table();
      test_random_traffic(225, 24, 50, sibs_pkg::DEPTH);
      test_random_traffic(225, 24, 50, $urandom_range(sibs_pkg::DEPTH - 1, 1));
      test_random_traffic(225, 50, 24, $urandom_range(3, 1));
      test_random_traffic(225, 50, 24, $urandom_range(sibs_pkg::DEPTH - 1, 1));
      test_backpressure();
      test_random_traffic(225, 0, 0, 511);
      test_random_traffic(225, 0, 0, $urandom_range(sibs_pkg::DEPTH - 1, 1));
      wait_idle();
      if (expected_lookups.size() != 0) errors++;
      $display("covered %0d searches and %0d table writes over empty, partial, full and",
               searches_sent, writes_sent);
      $display("saturated counts; %0d responses checked, %0d of them hits",
               lookups_checked, hits_seen);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/sibs_pkg.sv
hdl/sibs_datapath.sv
hdl/sibs_ctrl.sv
hdl/sorted_id_binary_search_core.sv
test/tb_top.sv
